FILE: sv/hsvled_pkg.sv
// Shared types and constants for the HSV to RGB LED dimmer pipeline.
// No dependencies; used by every module of the block.
package hsvled_pkg;

    localparam int unsigned W_CH = 8;

    localparam logic [W_CH-1:0] FULL_SCALE = 8'd255;
    localparam logic [W_CH-1:0] REGION_SPAN = 8'd43;

    localparam logic [2:0] REGION_0 = 3'd0;
    localparam logic [2:0] REGION_1 = 3'd1;
    localparam logic [2:0] REGION_2 = 3'd2;
    localparam logic [2:0] REGION_3 = 3'd3;
    localparam logic [2:0] REGION_4 = 3'd4;
    localparam logic [2:0] REGION_5 = 3'd5;

    typedef struct packed {
        logic [2:0]      region;
        logic [W_CH-1:0] frac;
        logic [W_CH-1:0] sat;
        logic [W_CH-1:0] val;
        logic [W_CH-1:0] bright;
    } t_hue_word;

    typedef struct packed {
        logic [2:0]      region;
        logic [W_CH-1:0] val;
        logic [W_CH-1:0] bright;
        logic [W_CH-1:0] p;
        logic [W_CH-1:0] q;
        logic [W_CH-1:0] t;
    } t_level_word;

    typedef struct packed {
        logic [W_CH-1:0] red;
        logic [W_CH-1:0] green;
        logic [W_CH-1:0] blue;
    } t_rgb_word;

endpackage

FILE: sv/hsvled_region.sv
// Stage 1: hue region and in-region fraction.
// Depends on hsvled_pkg.
module hsvled_region (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    output logic                  o_rdy,
    input  logic [7:0]            i_hue,
    input  logic [7:0]            i_sat,
    input  logic [7:0]            i_val,
    input  logic [7:0]            i_bright,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output hsvled_pkg::t_hue_word o_word
);

    logic                  r_vld;
    hsvled_pkg::t_hue_word r_word;
    hsvled_pkg::t_hue_word n_word;
    logic [2:0]            region;
    logic [7:0]            base;
    logic [7:0]            rem;

    always_comb begin
        region = {2'b00, i_hue >= 8'd43} + {2'b00, i_hue >= 8'd86}
               + {2'b00, i_hue >= 8'd129} + {2'b00, i_hue >= 8'd172}
               + {2'b00, i_hue >= 8'd215};
        case (region)
            hsvled_pkg::REGION_0: base = 8'd0;
            hsvled_pkg::REGION_1: base = 8'd43;
            hsvled_pkg::REGION_2: base = 8'd86;
            hsvled_pkg::REGION_3: base = 8'd129;
            hsvled_pkg::REGION_4: base = 8'd172;
            default:              base = 8'd215;
        endcase
        rem           = i_hue - base;
        n_word.region = region;
        n_word.frac   = (rem << 2) + (rem << 1);
        n_word.sat    = i_sat;
        n_word.val    = i_val;
        n_word.bright = i_bright;
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_word <= n_word;
        end
    end

    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_word.region <= hsvled_pkg::REGION_5 && r_word.frac <= 8'd252))
        else $error("region or fraction out of range");

endmodule

FILE: sv/hsvled_levels.sv
// Stages 2 and 3: p level and saturation terms, then q and t levels.
// Depends on hsvled_pkg.
module hsvled_levels (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  hsvled_pkg::t_hue_word   i_word,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output hsvled_pkg::t_level_word o_word
);

    logic                    r_vld2;
    logic                    r_vld3;
    logic                    rdy2;
    logic                    rdy3;
    hsvled_pkg::t_level_word r_s2;
    hsvled_pkg::t_level_word n_s2;
    hsvled_pkg::t_level_word r_s3;
    hsvled_pkg::t_level_word n_s3;
    logic [15:0]             prod_p;
    logic [15:0]             prod_a;
    logic [15:0]             prod_b;
    logic [15:0]             prod_q;
    logic [15:0]             prod_t;

    // stage 2: q and t slots carry sat*frac and sat*(255-frac) terms
    always_comb begin
        prod_p        = i_word.val * (hsvled_pkg::FULL_SCALE - i_word.sat);
        prod_a        = i_word.sat * i_word.frac;
        prod_b        = i_word.sat * (hsvled_pkg::FULL_SCALE - i_word.frac);
        n_s2.region   = i_word.region;
        n_s2.val      = i_word.val;
        n_s2.bright   = i_word.bright;
        n_s2.p        = prod_p[15:8];
        n_s2.q        = prod_a[15:8];
        n_s2.t        = prod_b[15:8];
    end

    always_comb begin
        prod_q      = r_s2.val * (hsvled_pkg::FULL_SCALE - r_s2.q);
        prod_t      = r_s2.val * (hsvled_pkg::FULL_SCALE - r_s2.t);
        n_s3        = r_s2;
        n_s3.q      = prod_q[15:8];
        n_s3.t      = prod_t[15:8];
    end

    assign rdy3   = !r_vld3 || i_rdy;
    assign rdy2   = !r_vld2 || rdy3;
    assign o_rdy  = rdy2;
    assign o_vld  = r_vld3;
    assign o_word = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_vld2 <= i_vld;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_vld) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_vld2) begin
            r_s3 <= n_s3;
        end
    end

    a_levels_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> (r_s3.p <= r_s3.val && r_s3.q <= r_s3.val && r_s3.t <= r_s3.val))
        else $error("level exceeds value");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && !i_rdy) |=> (r_vld3 && $stable(r_s3)))
        else $error("stalled level word changed");

endmodule

FILE: sv/hsvled_dim.sv
// Stages 4 and 5: channel selection and brightness product, then /255 and inversion.
// Depends on hsvled_pkg.
module hsvled_dim (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  hsvled_pkg::t_level_word i_word,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output hsvled_pkg::t_rgb_word   o_word
);

    logic                  r_vld4;
    logic                  r_vld5;
    logic                  rdy4;
    logic                  rdy5;
    logic [15:0]           r_prod_r;
    logic [15:0]           r_prod_g;
    logic [15:0]           r_prod_b;
    logic [15:0]           n_prod_r;
    logic [15:0]           n_prod_g;
    logic [15:0]           n_prod_b;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    hsvled_pkg::t_rgb_word r_out;
    hsvled_pkg::t_rgb_word n_out;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    always_comb begin
        case (i_word.region)
            hsvled_pkg::REGION_0: begin
                red = i_word.val; green = i_word.t;   blue = i_word.p;
            end
            hsvled_pkg::REGION_1: begin
                red = i_word.q;   green = i_word.val; blue = i_word.p;
            end
            hsvled_pkg::REGION_2: begin
                red = i_word.p;   green = i_word.val; blue = i_word.t;
            end
            hsvled_pkg::REGION_3: begin
                red = i_word.p;   green = i_word.q;   blue = i_word.val;
            end
            hsvled_pkg::REGION_4: begin
                red = i_word.t;   green = i_word.p;   blue = i_word.val;
            end
            default: begin
                red = i_word.val; green = i_word.p;   blue = i_word.q;
            end
        endcase
        n_prod_r = red * i_word.bright;
        n_prod_g = green * i_word.bright;
        n_prod_b = blue * i_word.bright;
    end

    always_comb begin
        n_out.red   = hsvled_pkg::FULL_SCALE - div255(r_prod_r);
        n_out.green = hsvled_pkg::FULL_SCALE - div255(r_prod_g);
        n_out.blue  = hsvled_pkg::FULL_SCALE - div255(r_prod_b);
    end

    assign rdy5   = !r_vld5 || i_rdy;
    assign rdy4   = !r_vld4 || rdy5;
    assign o_rdy  = rdy4;
    assign o_vld  = r_vld5;
    assign o_word = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy4) begin
                r_vld4 <= i_vld;
            end
            if (rdy5) begin
                r_vld5 <= r_vld4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_vld) begin
            r_prod_r <= n_prod_r;
            r_prod_g <= n_prod_g;
            r_prod_b <= n_prod_b;
        end
        if (rdy5 && r_vld4) begin
            r_out <= n_out;
        end
    end

    a_prod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (r_prod_r <= 16'd65025 && r_prod_g <= 16'd65025
                    && r_prod_b <= 16'd65025))
        else $error("brightness product out of range");

endmodule

FILE: sv/hsv_to_rgb_led_dimmer_unit.sv
// HSV to RGB LED dimmer: five register stages between accept and o_valid.
// Throughput one word per cycle while i_ready stays high; each stage advances when the next one is empty or moving.
// A stalled output word holds its stage and the stages behind it fill before o_ready drops.
// Synchronous active-low reset empties every stage; payload registers are not reset.
// Depends on hsvled_pkg, hsvled_region, hsvled_levels and hsvled_dim.
module hsv_to_rgb_led_dimmer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_value,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red_compare,
    output logic [7:0] o_green_compare,
    output logic [7:0] o_blue_compare
);

    logic                    vld1;
    logic                    rdy1;
    logic                    vld3;
    logic                    rdy3;
    hsvled_pkg::t_hue_word   word1;
    hsvled_pkg::t_level_word word3;
    hsvled_pkg::t_rgb_word   word5;

    hsvled_region u_region (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_valid),
        .o_rdy    (o_ready),
        .i_hue    (i_hue),
        .i_sat    (i_saturation),
        .i_val    (i_value),
        .i_bright (i_brightness),
        .o_vld    (vld1),
        .i_rdy    (rdy1),
        .o_word   (word1)
    );

    hsvled_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld1),
        .o_rdy   (rdy1),
        .i_word  (word1),
        .o_vld   (vld3),
        .i_rdy   (rdy3),
        .o_word  (word3)
    );

    hsvled_dim u_dim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld3),
        .o_rdy   (rdy3),
        .i_word  (word3),
        .o_vld   (o_valid),
        .i_rdy   (i_ready),
        .o_word  (word5)
    );

    assign o_red_compare   = word5.red;
    assign o_green_compare = word5.green;
    assign o_blue_compare  = word5.blue;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && vld1 && vld3 && !i_ready))
        else $error("input blocked with room in pipeline");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for hsv_to_rgb_led_dimmer_unit: HSV words in, PWM compare words out.
// Predicts every result in SystemVerilog and checks outputs in order under random stalls.
// Depends on hsvled_pkg and the hsv_to_rgb_led_dimmer_unit RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned FRAC_STEP   = 6;
    localparam int unsigned LEVEL_SHIFT = 8;
    localparam int unsigned RAND_WORDS  = 1000;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 60;

    typedef struct {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] bright;
    } t_hsv_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_hue = 8'd0;
    logic [7:0] i_saturation = 8'd0;
    logic [7:0] i_value = 8'd0;
    logic [7:0] i_brightness = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_red_compare;
    logic [7:0] o_green_compare;
    logic [7:0] o_blue_compare;

    t_hsv_item             pending_hsv[$];
    hsvled_pkg::t_rgb_word expected_rgb[$];
    int unsigned           words_in = 0;
    int unsigned           words_out = 0;
    int unsigned           fail_count = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           hold_left = 0;
    bit                    hold_done = 1'b0;
    bit                    in_taken = 1'b0;
    bit                    calm;

    hsv_to_rgb_led_dimmer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_hue           (i_hue),
        .i_saturation    (i_saturation),
        .i_value         (i_value),
        .i_brightness    (i_brightness),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_red_compare   (o_red_compare),
        .o_green_compare (o_green_compare),
        .o_blue_compare  (o_blue_compare)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // no random idling on either side for a stretch in the middle of the run
    assign calm = (words_in >= 500) && (words_in < 700);

    function automatic int unsigned dim_compare(int unsigned level, int unsigned bright);
        return hsvled_pkg::FULL_SCALE - ((level * bright) / hsvled_pkg::FULL_SCALE);
    endfunction

    function automatic hsvled_pkg::t_rgb_word hsv_dim_predict(t_hsv_item item);
        int unsigned           hue, sat, val, frac, p, q, t, r, g, b;
        logic [2:0]            region;
        hsvled_pkg::t_rgb_word res;
        hue    = item.hue;
        sat    = item.sat;
        val    = item.val;
        region = 3'(hue / hsvled_pkg::REGION_SPAN);
        frac   = (hue - region * hsvled_pkg::REGION_SPAN) * FRAC_STEP;
        p = (val * (hsvled_pkg::FULL_SCALE - sat)) >> LEVEL_SHIFT;
        q = (val * (hsvled_pkg::FULL_SCALE - ((sat * frac) >> LEVEL_SHIFT))) >> LEVEL_SHIFT;
        t = (val * (hsvled_pkg::FULL_SCALE
                    - ((sat * (hsvled_pkg::FULL_SCALE - frac)) >> LEVEL_SHIFT)))
            >> LEVEL_SHIFT;
        case (region)
            hsvled_pkg::REGION_0: begin r = val; g = t;   b = p;   end
            hsvled_pkg::REGION_1: begin r = q;   g = val; b = p;   end
            hsvled_pkg::REGION_2: begin r = p;   g = val; b = t;   end
            hsvled_pkg::REGION_3: begin r = p;   g = q;   b = val; end
            hsvled_pkg::REGION_4: begin r = t;   g = p;   b = val; end
            default:              begin r = val; g = p;   b = q;   end
        endcase
        res.red   = 8'(dim_compare(r, item.bright));
        res.green = 8'(dim_compare(g, item.bright));
        res.blue  = 8'(dim_compare(b, item.bright));
        return res;
    endfunction

    function automatic logic [7:0] edge_or_random();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_word(int unsigned hue, int unsigned sat, int unsigned val,
                              int unsigned bright);
        t_hsv_item item;
        item.hue    = 8'(hue);
        item.sat    = 8'(sat);
        item.val    = 8'(val);
        item.bright = 8'(bright);
        pending_hsv.push_back(item);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_hsv_item item;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_hsv.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                item = pending_hsv.pop_front();
                i_valid      <= 1'b1;
                i_hue        <= item.hue;
                i_saturation <= item.sat;
                i_value      <= item.val;
                i_brightness <= item.bright;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off to back the pipe up
    always @(negedge i_clk) begin
        if (!hold_done && words_out >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // input capture and prediction
    always @(posedge i_clk) begin
        t_hsv_item item;
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) begin
            item.hue    = i_hue;
            item.sat    = i_saturation;
            item.val    = i_value;
            item.bright = i_brightness;
            expected_rgb.push_back(hsv_dim_predict(item));
            words_in = words_in + 1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        hsvled_pkg::t_rgb_word exp_rgb;
        if (i_rst_n && o_valid && i_ready) begin
            words_out = words_out + 1;
            if (expected_rgb.size() == 0) begin
                $error("unexpected output word: red %0d green %0d blue %0d",
                       o_red_compare, o_green_compare, o_blue_compare);
                fail_count = fail_count + 1;
            end else begin
                exp_rgb = expected_rgb.pop_front();
                if (o_red_compare !== exp_rgb.red) begin
                    $error("red_compare: expected %0d, got %0d", exp_rgb.red, o_red_compare);
                    fail_count = fail_count + 1;
                end
                if (o_green_compare !== exp_rgb.green) begin
                    $error("green_compare: expected %0d, got %0d",
                           exp_rgb.green, o_green_compare);
                    fail_count = fail_count + 1;
                end
                if (o_blue_compare !== exp_rgb.blue) begin
                    $error("blue_compare: expected %0d, got %0d", exp_rgb.blue, o_blue_compare);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int unsigned hue_edges[12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};
        foreach (hue_edges[k]) begin
            queue_word(hue_edges[k], 255, 255, 255);
        end
        queue_word(0, 0, 0, 0);
        queue_word(100, 0, 200, 255);
        queue_word(60, 255, 0, 255);
        queue_word(150, 200, 255, 0);
        queue_word(20, 128, 255, 128);
        queue_word(255, 255, 1, 1);
        queue_word(230, 1, 254, 254);
        for (int n = 0; n < RAND_WORDS; n++) begin
            if ($urandom_range(0, 99) < 70) begin
                queue_word($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                queue_word($urandom_range(0, 255), edge_or_random(),
                           edge_or_random(), edge_or_random());
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_hsv.size() > 0 || i_valid || expected_rgb.size() > 0);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d words in, %0d words out: all hue regions and edges, random fields,",
                 words_in, words_out);
        $display("random stalls on both sides and one long output hold-off.");
        if (fail_count == 0 && expected_rgb.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
